/* sv/stepdir_pkg.sv */
// Shared types for the step/direction generator: command codes and the
// input word that travels from the input stage to the step core. No dependencies.
package stepdir_pkg;

  localparam int unsigned AmountBits = 32;
  localparam int unsigned StepDelayBits = 16;
  localparam int unsigned PositionOutBits = 32;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_POS  = 2'd1,
    OP_MOVE_ABS = 2'd2,
    OP_MOVE_REL = 2'd3
  } stepdir_op_e;

  typedef struct packed {
    stepdir_op_e                      op;
    logic signed [AmountBits-1:0]     amount;
    logic        [StepDelayBits-1:0]  step_delay;
  } stepdir_word_t;

  typedef struct packed {
    logic          valid;
    stepdir_word_t word;
  } stepdir_in_t;

endpackage

/* sv/stepdir_in_stage.sv */
// Input register of the step/direction generator: holds one accepted word
// until the step core takes it. Depends on stepdir_pkg.
module stepdir_in_stage
  import stepdir_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stepdir_word_t                   word_i,
  input  logic                            advance_i,
  output stepdir_in_t                     held_o
);

  logic          valid_q;
  stepdir_word_t word_q;

  // Stall only while a word is held and the core cannot take it this cycle.
  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= word_i;
    end
  end

  assign held_o.valid = valid_q;
  assign held_o.word  = word_q;

endmodule

/* sv/stepdir_core.sv */
// Step core: position, target, countdown and direction state, the single-pass
// update for one word, and the result register. Depends on stepdir_pkg.
module stepdir_core
  import stepdir_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned DELAY_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               invert_i,
  input  stepdir_in_t                        held_i,
  output logic                               advance_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               step_pulse_o,
  output logic                               dir_level_o,
  output logic signed [PositionOutBits-1:0]  position_o,
  output logic                               at_target_o
);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] tgt_q, tgt_d;
  logic [DELAY_BITS-1:0]    cnt_q, cnt_d;
  logic                     dir_q, dir_d;
  logic                     pulse_d;

  logic                     out_valid_q, out_valid_d;
  logic                     pulse_q;
  logic [PositionOutBits-1:0] pos_out_q;
  logic                     at_tgt_q;

  logic [63:0]              amt_ext;
  logic [POSITION_BITS-1:0] amt;
  logic [31:0]              dly_ext;
  logic [DELAY_BITS-1:0]    dly;
  logic [POSITION_BITS-1:0] diff;
  logic                     moving;
  logic                     forward;
  logic [63:0]              pos_ext;

  // Take the next word when the result slot is free or being drained.
  assign advance_o = held_i.valid && (!out_valid_q || !out_stall_i);

  assign amt_ext = 64'(held_i.word.amount);
  assign amt     = amt_ext[POSITION_BITS-1:0];
  assign dly_ext = 32'(held_i.word.step_delay);
  assign dly     = dly_ext[DELAY_BITS-1:0];
  assign diff    = tgt_q - pos_q;
  assign moving  = (diff != '0);
  assign forward = !diff[POSITION_BITS-1];

  always_comb begin
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    dir_d   = dir_q;
    pulse_d = 1'b0;
    unique case (held_i.word.op)
      OP_SET_POS: begin
        pos_d = amt;
        tgt_d = amt;
      end
      OP_MOVE_ABS: tgt_d = amt;
      OP_MOVE_REL: tgt_d = pos_q + amt;
      OP_TICK: begin
        if (moving) begin
          dir_d = forward ^ invert_i;
          if (cnt_q == '0) begin
            pulse_d = 1'b1;
            pos_d   = forward ? pos_q + 1'b1 : pos_q - 1'b1;
            cnt_d   = dly;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pos_ext = 64'(pos_d);

  always_comb begin
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      tgt_q       <= '0;
      cnt_q       <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        pos_q <= pos_d;
        tgt_q <= tgt_d;
        cnt_q <= cnt_d;
        dir_q <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      pulse_q   <= pulse_d;
      pos_out_q <= pos_ext[PositionOutBits-1:0];
      at_tgt_q  <= (pos_d == tgt_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign step_pulse_o = pulse_q;
  assign dir_level_o  = dir_q;
  assign position_o   = pos_out_q;
  assign at_target_o  = at_tgt_q;

endmodule

/* sv/stepper_step_dir_generator_unit.sv */
// Top level of the step/direction pulse generator: configuration register,
// input stage and step core. Depends on stepdir_pkg, stepdir_in_stage, stepdir_core.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------------
//   in       | in_valid_i / in_stall_o | op_i, amount_i, step_delay_i
//   out      | out_valid_o/out_stall_i | step_pulse_o, dir_level_o, position_o, at_target_o
//   cfg      | cfg_we_i                | cfg_data_i (invert_direction)
//
// Flow: one word per clock while the output does not stall; a word is loaded into the
//   input register on acceptance and moves into the result register when the core takes it.
// The step core updates position, target, countdown and direction in a single
//   pass when a word moves from the input register into the result register.
// Reset clears position, target, countdown, direction, the invert setting and
//   both valid flags; no clearing pass is needed.
// A stall on the output holds the result; the input register still takes one
//   more word, and in_stall_o rises only while that word cannot move on.
module stepper_step_dir_generator_unit
  import stepdir_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned DELAY_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic signed [AmountBits-1:0]       amount_i,
  input  logic [StepDelayBits-1:0]           step_delay_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               step_pulse_o,
  output logic                               dir_level_o,
  output logic signed [PositionOutBits-1:0]  position_o,
  output logic                               at_target_o
);

  logic          invert_q;
  stepdir_word_t word_in;
  stepdir_in_t   held;
  logic          advance;

  // Invert setting; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      invert_q <= cfg_data_i;
    end
  end

  assign word_in.op         = stepdir_op_e'(op_i);
  assign word_in.amount     = amount_i;
  assign word_in.step_delay = step_delay_i;

  stepdir_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .word_i     (word_in),
    .advance_i  (advance),
    .held_o     (held)
  );

  stepdir_core #(
    .POSITION_BITS (POSITION_BITS),
    .DELAY_BITS    (DELAY_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .invert_i     (invert_q),
    .held_i       (held),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_pulse_o (step_pulse_o),
    .dir_level_o  (dir_level_o),
    .position_o   (position_o),
    .at_target_o  (at_target_o)
  );

endmodule

/* dv/tb_stepper_step_dir_generator_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stepper_step_dir_generator_unit: directed and random
// tick/command words, with output stalls and sender gaps. Depends on stepdir_pkg.
module tb_stepper_step_dir_generator_unit;
  import stepdir_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_TOTAL = 400;
  localparam int unsigned SETTLE_EDGES = 4;

  // Receiver behavior while no long hold-off is pending.
  typedef enum int unsigned {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  // One expected result word, laid out like the output ports.
  typedef struct packed {
    logic                              step_pulse;
    logic                              dir_level;
    logic signed [PositionOutBits-1:0] position;
    logic                              at_target;
  } motion_result_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic                              cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [1:0]                        op_i;
  logic signed [AmountBits-1:0]      amount_i;
  logic [StepDelayBits-1:0]          step_delay_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              step_pulse_o;
  logic                              dir_level_o;
  logic signed [PositionOutBits-1:0] position_o;
  logic                              at_target_o;

  // Shadow of the block's state, advanced once per accepted word.
  logic [31:0]              motor_pos;
  logic [31:0]              motor_target;
  logic [StepDelayBits-1:0] steps_countdown;
  logic                     dir_line;
  logic                     invert_dir;

  motion_result_t expected_motion[$];
  int unsigned    error_count;
  int unsigned    words_sent;

  // Sender and receiver knobs, changed by the test tasks between phases.
  bit          sender_bursty;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned hold_off_cycles;
  int unsigned rx_phase;

  stepper_step_dir_generator_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .amount_i     (amount_i),
    .step_delay_i (step_delay_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_pulse_o (step_pulse_o),
    .dir_level_o  (dir_level_o),
    .position_o   (position_o),
    .at_target_o  (at_target_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Give up on a hung run: stop with an error report once the run reaches CYCLE_LIMIT.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Advance the shadow state by one word and return the result it must produce.
  // Ticks move the position one step toward the target when the countdown has
  // run out; commands only touch position and target.
  function automatic motion_result_t compute_motion(stepdir_op_e op, logic [31:0] amount,
                                                    logic [StepDelayBits-1:0] delay);
    motion_result_t res;
    logic [31:0]    gap_to_target;
    logic           forward;
    res.step_pulse = 1'b0;
    case (op)
      OP_SET_POS: begin
        motor_pos    = amount;
        motor_target = amount;
      end
      OP_MOVE_ABS: begin
        motor_target = amount;
      end
      OP_MOVE_REL: begin
        motor_target = motor_pos + amount;
      end
      default: begin
        gap_to_target = motor_target - motor_pos;
        if (gap_to_target != 32'd0) begin
          // Direction is the sign of the wrapped difference; half range counts as backward.
          forward  = ~gap_to_target[31];
          dir_line = forward ^ invert_dir;
          if (steps_countdown == '0) begin
            res.step_pulse  = 1'b1;
            motor_pos       = forward ? motor_pos + 32'd1 : motor_pos - 32'd1;
            steps_countdown = delay;
          end else begin
            steps_countdown = steps_countdown - 1'b1;
          end
        end else if (steps_countdown != '0) begin
          // Idle tick: the countdown still runs down, the direction line holds.
          steps_countdown = steps_countdown - 1'b1;
        end
      end
    endcase
    res.dir_level = dir_line;
    res.position  = motor_pos;
    res.at_target = (motor_pos == motor_target);
    return res;
  endfunction

  // Watch both channels and the config port at each edge. Values read here are
  // the ones from before the edge, so there is no race with the DUT's own flops.
  always @(posedge clk_i) begin
    motion_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_motion.size() == 0) begin
          $error("unexpected result word: position %0d", position_o);
          error_count++;
        end else begin
          want = expected_motion.pop_front();
          if (step_pulse_o !== want.step_pulse) begin
            $error("step_pulse: expected %0d, got %0d", want.step_pulse, step_pulse_o);
            error_count++;
          end
          if (dir_level_o !== want.dir_level) begin
            $error("dir_level: expected %0d, got %0d", want.dir_level, dir_level_o);
            error_count++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position_o);
            error_count++;
          end
          if (at_target_o !== want.at_target) begin
            $error("at_target: expected %0d, got %0d", want.at_target, at_target_o);
            error_count++;
          end
        end
      end
      if (cfg_we_i) invert_dir = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        expected_motion.push_back(compute_motion(stepdir_op_e'(op_i), amount_i, step_delay_i));
      end
    end
  end

  // Output side: a long hold-off wins; otherwise stall per the current mode.
  initial begin
    out_stall_i = 1'b0;
    rx_phase    = 0;
    forever begin
      @(posedge clk_i);
      rx_phase++;
      if (hold_off_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles--;
      end else begin
        case (rx_mode)
          RX_RANDOM:  out_stall_i <= ($urandom_range(0, 99) < 35);
          RX_PATTERN: out_stall_i <= ((rx_phase % 7) < 3);
          default:    out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Offer one word and hold it until accepted. In bursty mode, drop valid for a
  // random gap once the current burst runs out.
  task automatic send_word(stepdir_op_e op, logic [31:0] amount, logic [StepDelayBits-1:0] delay);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    amount_i     <= amount;
    step_delay_i <= delay;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering words until every expected result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (SETTLE_EDGES) @(posedge clk_i);
  endtask

  task automatic write_invert(logic value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_amount();
    return 32'($signed($urandom_range(0, 40)) - 20);
  endfunction

  // Extremes of every field, each op, wrap in both directions, the half-range
  // difference, idle ticks with the countdown running, ignored fields.
  task automatic test_directed();
    rx_mode       = RX_FREE;
    sender_bursty = 1'b0;
    send_word(OP_TICK,     32'h7FFF_FFFF, 16'hFFFF); // idle tick, amount and delay ignored
    send_word(OP_MOVE_ABS, 32'd3,         16'hAAAA);
    send_word(OP_TICK,     32'h0,         16'd1);
    send_word(OP_TICK,     32'hFFFF_FFFF, 16'h5555); // countdown falls, no step
    send_word(OP_TICK,     32'h0,         16'd0);
    send_word(OP_TICK,     32'h0,         16'd0);    // reaches target
    send_word(OP_TICK,     32'h0,         16'd2);    // idle
    send_word(OP_MOVE_REL, -32'sd5,       16'h0);
    send_word(OP_TICK,     32'h0,         16'd0);    // backward step
    send_word(OP_SET_POS,  32'h7FFF_FFFF, 16'h0);
    send_word(OP_MOVE_REL, 32'd1,         16'h0);    // target wraps to the minimum
    send_word(OP_TICK,     32'h0,         16'd0);    // position wraps forward
    send_word(OP_MOVE_ABS, 32'h7FFF_FFFF, 16'h0);
    send_word(OP_TICK,     32'h0,         16'd0);    // position wraps backward
    send_word(OP_SET_POS,  32'h0,         16'hFFFF);
    send_word(OP_MOVE_ABS, 32'h8000_0000, 16'h0);    // half range: sign bit says backward
    send_word(OP_TICK,     32'h0,         16'd3);
    send_word(OP_MOVE_REL, 32'h0,         16'h0);    // target onto position
    send_word(OP_TICK,     32'h0,         16'hFFFF); // idle, countdown 3 -> 2
    send_word(OP_TICK,     32'h0,         16'h0);
    send_word(OP_TICK,     32'h0,         16'h0);
    send_word(OP_SET_POS,  32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_MOVE_REL, 32'h7FFF_FFFF, 16'h0);
    send_word(OP_TICK,     32'h0,         16'd0);
  endtask

  // Invert setting: takes hold on the next tick with motion, dir holds until then.
  task automatic test_invert_setting();
    rx_mode       = RX_PATTERN;
    sender_bursty = 1'b1;
    write_invert(1'b1);
    send_word(OP_MOVE_REL, -32'sd2, 16'h0);
    send_word(OP_TICK,     32'h0,   16'd0);
    send_word(OP_TICK,     32'h0,   16'd0);
    send_word(OP_MOVE_REL, 32'd1,   16'h0);    // command: dir unchanged
    send_word(OP_TICK,     32'h0,   16'd0);
    write_invert(1'b0);
    send_word(OP_TICK,     32'h0,   16'd0);    // idle: old level held
    send_word(OP_MOVE_REL, -32'sd1, 16'h0);
    send_word(OP_TICK,     32'h0,   16'd0);
    write_invert(1'b1);
    write_invert(1'b1);
    send_word(OP_MOVE_REL, 32'd2,   16'h0);
    send_word(OP_TICK,     32'h0,   16'd1);
    send_word(OP_TICK,     32'h0,   16'd0);
    send_word(OP_TICK,     32'h0,   16'd0);
  endtask

  // Long output hold with the sender streaming, so the block backs up into
  // in_stall_o; then pause the sender until everything has come out.
  task automatic test_output_backpressure();
    int unsigned n;
    drain_results();
    rx_mode         = RX_FREE;
    sender_bursty   = 1'b0;
    hold_off_cycles = 60;
    send_word(OP_SET_POS, $urandom, 16'(($urandom)));
    send_word(OP_MOVE_REL, small_amount(), 16'h0);
    for (n = 0; n < 20; n++) send_word(OP_TICK, $urandom, 16'($urandom_range(0, 1)));
    drain_results();
  endtask

  // Mostly well-formed move sequences: a command, then a run of ticks with
  // short delays. A few words of noise in between.
  task automatic test_random_moves();
    int unsigned kind;
    int unsigned n;
    int unsigned ticks;
    int unsigned next_shake;
    logic [31:0] base;
    next_shake = words_sent + 60;
    while (words_sent < RANDOM_TOTAL) begin
      if (words_sent >= next_shake) begin
        next_shake    = words_sent + 60;
        rx_mode       = rx_mode_e'($urandom_range(0, 2));
        sender_bursty = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) write_invert(1'($urandom_range(0, 1)));
      end
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // Set somewhere (often near a wrap point), idle tick, then a short move.
            case ($urandom_range(0, 2))
              0:       base = $urandom;
              1:       base = 32'h7FFF_FFF8 + $urandom_range(0, 15);
              default: base = small_amount();
            endcase
            send_word(OP_SET_POS, base, 16'($urandom));
            send_word(OP_TICK, $urandom, 16'($urandom));
            send_word(OP_MOVE_REL, small_amount(), 16'($urandom));
          end
          3, 4, 5: send_word(OP_MOVE_REL, small_amount(), 16'($urandom));
          6, 7, 8: send_word(OP_MOVE_ABS, small_amount(), 16'($urandom));
          default: send_word(OP_MOVE_ABS, $urandom, 16'($urandom));
        endcase
        ticks = $urandom_range(1, 30);
        for (n = 0; n < ticks; n++) begin
          if ($urandom_range(0, 99) < 70)
            send_word(OP_TICK, $urandom, 16'd0);
          else if ($urandom_range(0, 99) < 95)
            send_word(OP_TICK, $urandom, 16'($urandom_range(1, 3)));
          else
            send_word(OP_TICK, $urandom, 16'($urandom_range(4, 15)));
        end
      end else begin
        ticks = $urandom_range(1, 4);
        for (n = 0; n < ticks; n++) begin
          kind = $urandom_range(0, 3);
          if (stepdir_op_e'(kind) == OP_TICK)
            send_word(OP_TICK, $urandom, 16'($urandom_range(0, 7)));
          else
            send_word(stepdir_op_e'(kind), $urandom, 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_TICK;
    amount_i        = '0;
    step_delay_i    = '0;
    motor_pos       = '0;
    motor_target    = '0;
    steps_countdown = '0;
    dir_line        = 1'b0;
    invert_dir      = 1'b0;
    error_count     = 0;
    words_sent      = 0;
    sender_bursty   = 1'b0;
    burst_left      = 0;
    rx_mode         = RX_FREE;
    hold_off_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_invert_setting();
    test_output_backpressure();
    test_random_moves();
    write_invert(1'b0);
    drain_results();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/stepdir_pkg.sv
sv/stepdir_in_stage.sv
sv/stepdir_core.sv
sv/stepper_step_dir_generator_unit.sv
dv/tb_stepper_step_dir_generator_unit.sv
